### rtl/core/dst_pkg.sv
`default_nettype none

package dst_pkg;

	localparam int unsigned MAX_PAYLOAD = 10;

	localparam logic [7:0]  SYSEX_START = 8'hF0;
	localparam logic [7:0]  SYSEX_END   = 8'hF7;
	localparam logic [15:0] TICKS_FULL  = 16'hFFFF;

	localparam int unsigned COUNT_W = 4;
	localparam int unsigned FIRST_W = 56;
	localparam int unsigned LAST_W  = 14;
	localparam int unsigned DEB_W   = 10;
	localparam int unsigned CFG_W   = 56;

	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		CFG_PAYLOAD_COUNT = 3'd0,
		CFG_FIRST_EIGHT   = 3'd1,
		CFG_LAST_TWO      = 3'd2,
		CFG_INVERT        = 3'd3,
		CFG_DEBOUNCE      = 3'd4
	} cfg_index_t;

	// Status of the message queue as seen by the front and the back.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Payload byte n, counted from one.
	function automatic logic [6:0] payload_byte(
		input logic [FIRST_W-1:0] first,
		input logic [LAST_W-1:0]  last,
		input count_t             n
	);
		logic [6:0] b;
		unique case (n)
			4'd1:    b = first[6:0];
			4'd2:    b = first[13:7];
			4'd3:    b = first[20:14];
			4'd4:    b = first[27:21];
			4'd5:    b = first[34:28];
			4'd6:    b = first[41:35];
			4'd7:    b = first[48:42];
			4'd8:    b = first[55:49];
			4'd9:    b = last[6:0];
			4'd10:   b = last[13:7];
			default: b = 7'd0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/core/debounced_sysex_trigger.sv
`default_nettype none

// Debounced push button that sends a MIDI System Exclusive message on each
// press. Every input item is one millisecond tick carrying the raw pin level
// (0 is pressed with a pull-up), optionally inverted by invert_input. The
// level is accepted as stable once it has held unchanged for more than
// debounce_ticks ticks; a stable change from released to pressed emits
// 0xF0, then payload_count seven-bit payload bytes, then 0xF7, which alone
// carries last_byte. A payload_count of 0 or above ten sends nothing, and
// releases never send. The front stage takes one tick per clock cycle and
// writes each press into a queue of QUEUE_DEPTH pending messages; the back
// sequencer drains the head message one byte per cycle through its output
// register while out_stall is low; a message of N payload bytes is N + 2
// bytes, twelve for the longest. The input stalls only while the queue is
// full. Configuration is a plain write port (cfg_we, cfg_index, cfg_data)
// and should be written only while no message is pending or being sent.
module debounced_sysex_trigger
	import dst_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             pin_level,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            midi_byte,
	output logic                  last_byte
);

	count_t             payload_count_q;
	logic [FIRST_W-1:0] payload_first_eight_q;
	logic [LAST_W-1:0]  payload_last_two_q;
	logic               invert_input_q;
	logic [DEB_W-1:0]   debounce_ticks_q;

	logic      tick_accept;
	logic      push;
	count_t    push_count;
	logic      pop;
	count_t    head_count;
	q_status_t q_status;

	// Configuration registers, written directly by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_count_q       <= '0;
			payload_first_eight_q <= '0;
			payload_last_two_q    <= '0;
			invert_input_q        <= 1'b0;
			debounce_ticks_q      <= DEB_W'(25);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAYLOAD_COUNT: payload_count_q       <= cfg_data[COUNT_W-1:0];
				CFG_FIRST_EIGHT:   payload_first_eight_q <= cfg_data[FIRST_W-1:0];
				CFG_LAST_TWO:      payload_last_two_q    <= cfg_data[LAST_W-1:0];
				CFG_INVERT:        invert_input_q        <= cfg_data[0];
				CFG_DEBOUNCE:      debounce_ticks_q      <= cfg_data[DEB_W-1:0];
				default: ;
			endcase
		end
	end

	// A tick is held off only while the queue has no room for a new message.
	assign in_stall    = q_status.full;
	assign tick_accept = in_valid && !in_stall;

	dst_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_accept    (tick_accept),
		.pin_level      (pin_level),
		.invert_input   (invert_input_q),
		.debounce_ticks (debounce_ticks_q),
		.payload_count  (payload_count_q),
		.push           (push),
		.push_count     (push_count)
	);

	dst_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_count (push_count),
		.pop        (pop),
		.head_count (head_count),
		.status     (q_status)
	);

	dst_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_status            (q_status),
		.head_count          (head_count),
		.pop                 (pop),
		.payload_first_eight (payload_first_eight_q),
		.payload_last_two    (payload_last_two_q),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.midi_byte           (midi_byte),
		.last_byte           (last_byte)
	);

endmodule

`default_nettype wire

### rtl/core/dst_front.sv
`default_nettype none

module dst_front
	import dst_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tick_accept,
	input  wire logic             pin_level,
	input  wire logic             invert_input,
	input  wire logic [DEB_W-1:0] debounce_ticks,
	input  wire count_t           payload_count,
	output logic                  push,
	output count_t                push_count
);

	logic        stable_q;
	logic        prev_raw_q;
	logic [15:0] ticks_q;
	logic        level;
	logic [15:0] ticks_inc;
	logic        settle;
	logic        count_ok;

	assign level     = pin_level ^ invert_input;
	assign ticks_inc = (ticks_q == TICKS_FULL) ? ticks_q : ticks_q + 16'd1;
	assign settle    = (ticks_inc > {{(16-DEB_W){1'b0}}, debounce_ticks})
	                   && (level != stable_q);
	assign count_ok  = (payload_count != '0)
	                   && (payload_count <= COUNT_W'(MAX_PAYLOAD));

	// A press is a settled change from released to pressed.
	assign push       = tick_accept && settle && stable_q && !level && count_ok;
	assign push_count = payload_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b1;
			prev_raw_q <= 1'b1;
			ticks_q    <= '0;
		end else if (tick_accept) begin
			if (settle) begin
				stable_q <= level;
			end
			if (level != prev_raw_q) begin
				ticks_q    <= '0;
				prev_raw_q <= level;
			end else begin
				ticks_q <= ticks_inc;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/dst_queue.sv
`default_nettype none

module dst_queue
	import dst_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire count_t push_count,
	input  wire logic   pop,
	output count_t      head_count,
	output q_status_t   status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	count_t              entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [FILL_W-1:0]   fill_q;

	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == FILL_W'(DEPTH));
	assign head_count   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("message queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop)
		else $error("message queue read while empty");

endmodule

`default_nettype wire

### rtl/core/dst_back.sv
`default_nettype none

module dst_back
	import dst_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire q_status_t          q_status,
	input  wire count_t             head_count,
	output logic                    pop,
	input  wire logic [FIRST_W-1:0] payload_first_eight,
	input  wire logic [LAST_W-1:0]  payload_last_two,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              midi_byte,
	output logic                    last_byte
);

	logic       busy_q;
	count_t     idx_q;
	count_t     cnt_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       out_free;
	logic       at_end;

	assign out_free  = !out_valid_q || !out_stall;
	assign at_end    = ({1'b0, idx_q} == ({1'b0, cnt_q} + 5'd1));
	assign pop       = out_free && !busy_q && !q_status.empty;
	assign out_valid = out_valid_q;
	assign midi_byte = byte_q;
	assign last_byte = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else if (out_free) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (at_end) begin
					byte_q <= SYSEX_END;
					last_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					byte_q <= {1'b0,
						payload_byte(payload_first_eight, payload_last_two, idx_q)};
					last_q <= 1'b0;
					idx_q  <= idx_q + 1'b1;
				end
			end else if (!q_status.empty) begin
				out_valid_q <= 1'b1;
				byte_q      <= SYSEX_START;
				last_q      <= 1'b0;
				busy_q      <= 1'b1;
				idx_q       <= 4'd1;
				cnt_q       <= head_count;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (byte_q == SYSEX_END))
		else $error("last byte is not the closing byte");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (({1'b0, idx_q} <= ({1'b0, cnt_q} + 5'd1)) && (idx_q != '0)))
		else $error("byte index ran past the message");

endmodule

`default_nettype wire

### dv/tb_debounced_sysex_trigger.sv
`timescale 1ns / 1ps

module tb_debounced_sysex_trigger;

	import dst_pkg::*;

	// Pipeline drain allowance: the longest message is twelve bytes at the
	// output, and a tick that sends nothing may still be in flight.
	localparam int DRAIN_CYCLES   = 24;
	// The receiver holds off this long once, so that the message queue fills.
	localparam int HOLD_CYCLES    = 300;
	// Cycles with no handshake and no register write before the run is given up.
	localparam int WATCHDOG_LIMIT = 3000;

	// One byte of a SysEx message as it leaves the block.
	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} sysex_byte_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic             pin_level = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       midi_byte;
	logic             last_byte;

	debounced_sysex_trigger DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pin_level (pin_level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.midi_byte (midi_byte),
		.last_byte (last_byte)
	);

	always #5 clk = ~clk;

	// Raw pin levels waiting to be offered to the block, one per tick.
	logic        pending_levels[$];
	// Message bytes the block owes us, oldest first.
	sysex_byte_t sysex_expected[$];

	int errors       = 0;
	int quiet_cycles = 0;
	// Random idling on both sides; it is switched off for the last part.
	bit idle_on      = 1'b1;
	// Set once by the stimulus to ask the receiver for its long hold-off.
	bit hold_request = 1'b0;

	// Our own copy of the configuration registers, already masked to width.
	count_t           pred_count;
	logic [FIRST_W-1:0] pred_bytes_lo;
	logic [LAST_W-1:0]  pred_bytes_hi;
	logic             pred_invert;
	logic [DEB_W-1:0] pred_debounce;

	// Our own copy of the debouncer state.
	logic        pred_stable;
	logic        pred_prev_raw;
	logic [15:0] pred_ticks;

	// One millisecond tick of the debouncer. The elapsed counter steps first,
	// then the stable level is tested, and only then is a raw change noted.
	// A press with a valid payload count queues the whole SysEx message.
	task automatic debounce_tick(input logic raw);
		logic                     lvl;
		logic                     was_released;
		logic [FIRST_W+LAST_W-1:0] payload_bits;
		lvl          = raw ^ pred_invert;
		payload_bits = {pred_bytes_hi, pred_bytes_lo};
		if (pred_ticks != TICKS_FULL) begin
			pred_ticks = pred_ticks + 16'd1;
		end
		if (pred_ticks > {6'd0, pred_debounce} && lvl != pred_stable) begin
			was_released = pred_stable;
			pred_stable  = lvl;
			// Only a press sends, and only with a payload count of one to ten.
			if (was_released && !lvl && pred_count >= 4'd1 && pred_count <= MAX_PAYLOAD) begin
				sysex_expected.push_back('{data: SYSEX_START, is_last: 1'b0});
				for (int n = 0; n < int'(pred_count); n++) begin
					sysex_expected.push_back('{data: {1'b0, payload_bits[7*n +: 7]},
						is_last: 1'b0});
				end
				sysex_expected.push_back('{data: SYSEX_END, is_last: 1'b1});
			end
		end
		if (lvl != pred_prev_raw) begin
			pred_ticks    = 16'd0;
			pred_prev_raw = lvl;
		end
	endtask

	// Driver: offers the pending pin levels, holding each one while stalled.
	// The prediction runs at the edge where the item is accepted.
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			pin_level <= 1'b0;
			in_gap    <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				debounce_tick(pin_level);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (pending_levels.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 5) == 0) begin
					// A gap before the next item.
					in_valid <= 1'b0;
					in_gap   <= $urandom_range(0, 2);
				end else begin
					in_valid  <= 1'b1;
					pin_level <= pending_levels.pop_front();
				end
			end
		end
	end

	// Monitor: checks each accepted byte against the oldest expectation and
	// decides the receiver's stall for the next cycle.
	int          out_gap;
	int          hold_left;
	bit          hold_served;
	sysex_byte_t head_byte;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			out_gap     <= 0;
			hold_left   <= 0;
			hold_served <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sysex_expected.size() == 0) begin
					$display("%0t: unexpected byte: expected none, got midi_byte %02h last_byte %0b",
						$time, midi_byte, last_byte);
					errors++;
				end else begin
					head_byte = sysex_expected.pop_front();
					if (midi_byte !== head_byte.data) begin
						$display("%0t: midi_byte mismatch: expected %02h, got %02h",
							$time, head_byte.data, midi_byte);
						errors++;
					end
					if (last_byte !== head_byte.is_last) begin
						$display("%0t: last_byte mismatch: expected %0b, got %0b",
							$time, head_byte.is_last, last_byte);
						errors++;
					end
				end
			end
			if (hold_request && !hold_served) begin
				// The long hold-off, counted down here while the sender keeps going.
				hold_served <= 1'b1;
				hold_left   <= HOLD_CYCLES;
				out_stall   <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap   <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				out_gap   <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL debounced_sysex_trigger");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [CFG_W-1:0] rand56();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[CFG_W-1:0];
	endfunction

	// Waits, sampling away from the clock edge, until every item has been
	// taken and every expected byte has arrived, then lets the pipeline drain.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_levels.size() != 0 || in_valid || sysex_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes one register once the block is idle and mirrors it, masked to
	// the register's width, into the predictor's configuration.
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_PAYLOAD_COUNT: pred_count    = data[COUNT_W-1:0];
			CFG_FIRST_EIGHT:   pred_bytes_lo = data[FIRST_W-1:0];
			CFG_LAST_TWO:      pred_bytes_hi = data[LAST_W-1:0];
			CFG_INVERT:        pred_invert   = data[0];
			CFG_DEBOUNCE:      pred_debounce = data[DEB_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all five registers. Bits above each register's width carry
	// random junk, which the block must ignore.
	task automatic set_all(input count_t cnt, input logic [FIRST_W-1:0] lo,
		input logic [LAST_W-1:0] hi, input logic inv, input logic [DEB_W-1:0] deb);
		logic [CFG_W-1:0] d;
		d = rand56();
		d[COUNT_W-1:0] = cnt;
		write_reg(CFG_PAYLOAD_COUNT, d);
		write_reg(CFG_FIRST_EIGHT, lo);
		d = rand56();
		d[LAST_W-1:0] = hi;
		write_reg(CFG_LAST_TWO, d);
		d = rand56();
		d[0] = inv;
		write_reg(CFG_INVERT, d);
		d = rand56();
		d[DEB_W-1:0] = deb;
		write_reg(CFG_DEBOUNCE, d);
	endtask

	task automatic queue_level(input logic lvl, input int n);
		for (int i = 0; i < n; i++) begin
			pending_levels.push_back(lvl);
		end
	endtask

	// One random setting followed by button activity. Most of it is clean
	// presses and releases that outlast the debounce time; the rest is
	// bounces shorter than it and single-tick noise.
	task automatic random_phase(input int n_items);
		count_t           cnt;
		logic [DEB_W-1:0] deb;
		logic             lvl;
		int               run;
		int               left;
		int               pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			cnt = count_t'($urandom_range(11, 15));
		end else if (pick == 1) begin
			cnt = '0;
		end else begin
			cnt = count_t'($urandom_range(1, MAX_PAYLOAD));
		end
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			deb = DEB_W'($urandom_range(0, 4));
		end else if (pick < 9) begin
			deb = DEB_W'($urandom_range(5, 12));
		end else begin
			deb = DEB_W'($urandom_range(13, 40));
		end
		set_all(cnt, rand56(), LAST_W'($urandom()), 1'($urandom_range(0, 1)), deb);
		left = n_items;
		lvl  = 1'($urandom_range(0, 1));
		while (left > 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				run = int'(deb) + 2 + $urandom_range(0, 3);
			end else if (pick < 9) begin
				run = $urandom_range(1, int'(deb) + 1);
			end else begin
				run = 0;
				for (int i = 0; i < 3 && left > 0; i++) begin
					queue_level(1'($urandom_range(0, 1)), 1);
					left--;
				end
			end
			if (run > left) begin
				run = left;
			end
			queue_level(lvl, run);
			left -= run;
			lvl = ~lvl;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] d;

		// Predictor state matching the block after reset.
		pred_count    = '0;
		pred_bytes_lo = '0;
		pred_bytes_hi = '0;
		pred_invert   = 1'b0;
		pred_debounce = DEB_W'(25);
		pred_stable   = 1'b1;
		pred_prev_raw = 1'b1;
		pred_ticks    = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A one-byte message with every payload bit set, then a release, then
		// a single-tick press after a long hold and a short bounce back.
		set_all(count_t'(1), '1, '1, 1'b0, DEB_W'(2));
		queue_level(1'b0, 4);
		queue_level(1'b1, 4);
		queue_level(1'b0, 1);
		queue_level(1'b1, 4);

		// The longest message with no debounce at all; bytes nine and ten
		// differ from byte eight.
		set_all(count_t'(MAX_PAYLOAD), '0, '1, 1'b0, '0);
		queue_level(1'b0, 1);
		queue_level(1'b1, 1);

		// Payload counts that must send nothing even though the press is taken.
		d = rand56();
		d[COUNT_W-1:0] = count_t'(11);
		write_reg(CFG_PAYLOAD_COUNT, d);
		queue_level(1'b0, 1);
		queue_level(1'b1, 1);
		d[COUNT_W-1:0] = '1;
		write_reg(CFG_PAYLOAD_COUNT, d);
		queue_level(1'b0, 1);
		queue_level(1'b1, 1);
		d[COUNT_W-1:0] = '0;
		write_reg(CFG_PAYLOAD_COUNT, d);
		queue_level(1'b0, 1);
		queue_level(1'b1, 1);

		// Inverted pin: a high pin is now a press.
		set_all(count_t'(2), rand56(), LAST_W'($urandom()), 1'b1, '0);
		queue_level(1'b1, 1);
		queue_level(1'b0, 1);
		queue_level(1'b1, 1);
		queue_level(1'b0, 1);

		// Back-to-back longest messages while the receiver holds off, so the
		// message queue fills and the input has to stall.
		set_all(count_t'(MAX_PAYLOAD), rand56(), LAST_W'($urandom()), 1'b0, '0);
		hold_request = 1'b1;
		for (int i = 0; i < 20; i++) begin
			queue_level(1'b0, 1);
			queue_level(1'b1, 1);
		end

		for (int p = 0; p < 4; p++) begin
			random_phase(55);
		end

		// The last stretch runs with both sides at full speed.
		wait_drained();
		idle_on = 1'b0;
		random_phase(55);

		wait_drained();
		if (errors == 0) begin
			$display("PASS debounced_sysex_trigger");
		end else begin
			$display("FAIL debounced_sysex_trigger");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/dst_pkg.sv
rtl/core/dst_front.sv
rtl/core/dst_queue.sv
rtl/core/dst_back.sv
rtl/core/debounced_sysex_trigger.sv
dv/tb_debounced_sysex_trigger.sv
